// File: hdl/tams_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tams_pkg: shared types and constants
// Field widths, servo arithmetic constants and the controller to datapath
// command and status structs of the moving average servo block.
// ----------------------------------------------------------------------------
package tams_pkg;

    localparam int ACC_W    = 16;
    localparam int PULSE_W  = 12;
    localparam int HELD_W   = 5;
    localparam int CFG_W    = 5;
    localparam int ANGLE_W  = 8;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd10;

    localparam logic signed [ACC_W-1:0] ONE_G     = 16'sd16384;
    localparam logic signed [ACC_W-1:0] NEG_ONE_G = -16'sd16384;
    localparam logic [6:0]  ANGLE_HALF  = 7'd90;
    // Pulse step per degree is 100/9 us, scaled by 2^16 and rounded up.
    localparam logic [19:0] PULSE_RECIP = 20'd728178;
    localparam int          RECIP_SHIFT = 16;
    localparam logic [PULSE_W-1:0] PULSE_MIN_US = 12'd500;
    localparam logic [PULSE_W-1:0] PULSE_MAX_US = 12'd2500;

    typedef struct packed {
        logic load_in;
        logic update;
        logic div_start;
        logic div_step;
        logic mean;
        logic angle;
        logic pulse;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

// File: hdl/tams_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tams_if: item channels
// Valid/ready channels for accelerometer samples and for averaged results.
// ----------------------------------------------------------------------------
interface tams_in_if import tams_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;

    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tams_out_if import tams_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] mean_x;
    logic signed [ACC_W-1:0] mean_y;
    logic signed [ACC_W-1:0] mean_z;
    logic [PULSE_W-1:0]      servo_pulse_us;
    logic [HELD_W-1:0]       samples_held;

    modport source (output valid, mean_x, mean_y, mean_z, servo_pulse_us, samples_held,
                    input ready);
    modport sink   (input valid, mean_x, mean_y, mean_z, servo_pulse_us, samples_held,
                    output ready);
endinterface

// File: hdl/tams_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tams_ctrl: sequencing controller
// Steps one item through ring update, serial division and servo mapping,
// and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module tams_ctrl import tams_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_UPDATE, S_DSTART, S_DIV, S_MEAN, S_ANGLE, S_PULSE, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.mean = 1'b1;
                n_state    = S_ANGLE;
            end
            S_ANGLE: begin
                o_cmd.angle = 1'b1;
                n_state     = S_PULSE;
            end
            S_PULSE: begin
                o_cmd.pulse = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hdl/tams_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tams_datapath: window storage and arithmetic
// Sample ring, running sums, three serial dividers, servo mapping and the
// output payload register.
// ----------------------------------------------------------------------------
module tams_datapath import tams_pkg::*; #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic signed [ACC_W-1:0] i_accel_x,
    input  logic signed [ACC_W-1:0] i_accel_y,
    input  logic signed [ACC_W-1:0] i_accel_z,
    output logic signed [ACC_W-1:0] o_mean_x,
    output logic signed [ACC_W-1:0] o_mean_y,
    output logic signed [ACC_W-1:0] o_mean_z,
    output logic [PULSE_W-1:0]      o_servo_pulse_us,
    output logic [HELD_W-1:0]       o_samples_held
);

    localparam int CW  = $clog2(MAX_WINDOW + 1);
    localparam int PW  = $clog2(MAX_WINDOW);
    localparam int SW  = ACC_W + $clog2(MAX_WINDOW) + 1;
    localparam int DCW = $clog2(SW);

    logic [CFG_W-1:0]        r_window_length;
    logic [PW-1:0]           r_pos;
    logic [PW-1:0]           r_pos_cur;
    logic [CW-1:0]           r_fill;
    logic                    r_full;
    logic signed [SW-1:0]    r_sum [3];
    logic signed [ACC_W-1:0] r_in  [3];
    logic [3*ACC_W-1:0]      r_rd;
    logic [3*ACC_W-1:0]      r_ring [MAX_WINDOW];
    logic [CW-1:0]           r_rem [3];
    logic [SW-1:0]           r_quo [3];
    logic                    r_neg [3];
    logic [DCW-1:0]          r_cnt;
    logic signed [ACC_W-1:0] r_mean [3];
    logic [ANGLE_W-1:0]      r_angle;
    logic [PULSE_W-1:0]      r_pulse;
    logic signed [ACC_W-1:0] r_o_mean [3];
    logic [PULSE_W-1:0]      r_o_pulse;
    logic [HELD_W-1:0]       r_o_held;

    logic [CW-1:0]           w_wl;
    logic [PW-1:0]           w_pos_eff;
    logic [CW-1:0]           w_pos_inc;
    logic signed [ACC_W-1:0] w_old [3];
    logic [CW:0]             w_trial [3];
    logic                    w_qbit [3];
    logic signed [ACC_W-1:0] w_clamp;
    logic [ACC_W:0]          w_offset;
    logic [21:0]             w_angle_prod;
    logic [27:0]             w_pulse_prod;

    always_comb begin
        if (r_window_length == '0) begin
            w_wl = CW'(1);
        end else if (32'(r_window_length) > 32'(MAX_WINDOW)) begin
            w_wl = CW'(MAX_WINDOW);
        end else begin
            w_wl = CW'(r_window_length);
        end
    end

    assign w_pos_eff = (CW'(r_pos) >= w_wl) ? '0 : r_pos;
    assign w_pos_inc = CW'(r_pos_cur) + CW'(1);

    assign w_old[0] = r_rd[ACC_W-1:0];
    assign w_old[1] = r_rd[2*ACC_W-1:ACC_W];
    assign w_old[2] = r_rd[3*ACC_W-1:2*ACC_W];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_trial[i] = {r_rem[i], r_quo[i][SW-1]};
            w_qbit[i]  = (w_trial[i] >= (CW+1)'(r_fill));
        end
    end

    always_comb begin
        if (r_mean[0] < NEG_ONE_G) begin
            w_clamp = NEG_ONE_G;
        end else if (r_mean[0] > ONE_G) begin
            w_clamp = ONE_G;
        end else begin
            w_clamp = r_mean[0];
        end
    end

    assign w_offset     = (ACC_W+1)'(w_clamp) + (ACC_W+1)'(ONE_G);
    assign w_angle_prod = 22'(w_offset) * 22'(ANGLE_HALF);
    assign w_pulse_prod = 28'(r_angle) * 28'(PULSE_RECIP);

    assign o_status.div_done = (r_cnt == DCW'(SW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_RESET;
            r_pos           <= '0;
            r_fill          <= '0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_window_length <= i_cfg_wdata;
            r_pos           <= '0;
            r_fill          <= '0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else if (i_cmd.update) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= r_sum[i] - (r_full ? SW'(w_old[i]) : SW'(0)) + SW'(r_in[i]);
            end
            r_fill <= r_full ? w_wl : r_fill + CW'(1);
            r_pos  <= (w_pos_inc >= w_wl) ? '0 : PW'(w_pos_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in[0]   <= i_accel_x;
            r_in[1]   <= i_accel_y;
            r_in[2]   <= i_accel_z;
            r_pos_cur <= w_pos_eff;
            r_full    <= (r_fill >= w_wl);
            r_rd      <= r_ring[w_pos_eff];
        end
        if (i_cmd.update) begin
            r_ring[r_pos_cur] <= {r_in[2], r_in[1], r_in[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_cnt <= '0;
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_sum[i][SW-1];
                r_quo[i] <= r_sum[i][SW-1] ? SW'(-r_sum[i]) : SW'(r_sum[i]);
                r_rem[i] <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + DCW'(1);
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= w_qbit[i] ? CW'(w_trial[i] - (CW+1)'(r_fill))
                                      : w_trial[i][CW-1:0];
                r_quo[i] <= {r_quo[i][SW-2:0], w_qbit[i]};
            end
        end
        if (i_cmd.mean) begin
            for (int i = 0; i < 3; i++) begin
                r_mean[i] <= r_neg[i] ? -$signed(r_quo[i][ACC_W-1:0])
                                      : $signed(r_quo[i][ACC_W-1:0]);
            end
        end
        if (i_cmd.angle) begin
            r_angle <= w_angle_prod[21:14];
        end
        if (i_cmd.pulse) begin
            r_pulse <= PULSE_MIN_US + w_pulse_prod[RECIP_SHIFT+PULSE_W-1:RECIP_SHIFT];
        end
        if (i_cmd.out_load) begin
            for (int i = 0; i < 3; i++) begin
                r_o_mean[i] <= r_mean[i];
            end
            r_o_pulse <= r_pulse;
            r_o_held  <= HELD_W'(r_fill);
        end
    end

    assign o_mean_x         = r_o_mean[0];
    assign o_mean_y         = r_o_mean[1];
    assign o_mean_z         = r_o_mean[2];
    assign o_servo_pulse_us = r_o_pulse;
    assign o_samples_held   = r_o_held;

endmodule

// File: hdl/three_axis_moving_average_servo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_moving_average_servo: windowed accelerometer mean and servo pulse
// Averages the last window_length samples per axis and maps mean x to a
// servo pulse width in microseconds.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on i_in (valid/ready) and results leave on o_out. One item
// in gives exactly one result: the three means, the pulse width and the
// number of samples averaged.
// After acceptance an item passes, in order, through the ring and sum
// update, the divider load, the steps of the three bit-serial dividers
// (one per bit of the 21-bit sum at MAX_WINDOW of 16), the mean step, the
// angle and pulse steps of servo mapping and the output register load.
// The dividers take the largest share of this sequence; a new item is
// accepted only after the last one has been loaded into the output register.
// i_in.ready is high while no item is in work; a waiting result in the
// output register does not hold it low. If the receiver stalls, the block
// finishes the next item and holds it until the output register is free.
// Reset sets window_length to 10 and empties the window; writing i_cfg_wdata
// with i_cfg_we high does the same with the new length. The user does so only
// while the block is idle (not enforced). The sample ring needs no clearing.
// ----------------------------------------------------------------------------
module three_axis_moving_average_servo import tams_pkg::*; #(
    parameter int MAX_WINDOW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    tams_in_if.sink          i_in,
    tams_out_if.source       o_out
);

    t_cmd    w_cmd;
    t_status w_status;

    tams_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tams_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_accel_x        (i_in.accel_x),
        .i_accel_y        (i_in.accel_y),
        .i_accel_z        (i_in.accel_z),
        .o_mean_x         (o_out.mean_x),
        .o_mean_y         (o_out.mean_y),
        .o_mean_z         (o_out.mean_z),
        .o_servo_pulse_us (o_out.servo_pulse_us),
        .o_samples_held   (o_out.samples_held)
    );

`ifndef SYNTHESIS
    a_one_item_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("A second item was accepted while one is in work.");

    a_held_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.samples_held != '0 &&
                         32'(o_out.samples_held) <= 32'(MAX_WINDOW)))
        else $error("Result reports a sample count outside the window.");

    a_pulse_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.servo_pulse_us >= PULSE_MIN_US &&
                         o_out.servo_pulse_us <= PULSE_MAX_US))
        else $error("Servo pulse width is outside its range.");
`endif

endmodule
